>>> rtl/gsd_pkg.sv
// gsd_pkg: shared types and event codes for the gif stream deframer
// no dependencies

`default_nettype none

package gsd_pkg;

  localparam int unsigned QDepth = 2;

  typedef enum logic [3:0] {
    EV_SCREEN    = 4'd0,
    EV_GPAL      = 4'd1,
    EV_TRANSP    = 4'd2,
    EV_DESC      = 4'd3,
    EV_LPAL      = 4'd4,
    EV_CODE_SIZE = 4'd5,
    EV_DATA      = 4'd6,
    EV_END       = 4'd7,
    EV_ERROR     = 4'd8
  } gsd_event_e;

  typedef struct packed {
    gsd_event_e  event_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [3:0]  pixel_depth;
    logic [7:0]  background_index;
    logic        is_interlaced;
    logic [7:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  data_value;
  } gsd_item_t;

endpackage

`default_nettype wire

>>> rtl/gif_stream_deframer.sv
// gif_stream_deframer: top level, parser front, event queue and output stage
// depends on gsd_pkg, gsd_front, gsd_queue, gsd_back

// Parses a GIF container one byte per input transfer and reports screen header, palette
// entries, transparency, image descriptor, code size, data bytes, end and error events,
// at most one result per byte. One byte is taken every clock cycle while the output side
// keeps up, since the parser handles each byte with one combinational state update. A result
// passes through the two-entry event queue and then the output register, and the input
// stalls only when both are full. A start_of_stream flag restarts parsing.

`default_nettype none

module gif_stream_deframer import gsd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // byte_in
  input  wire logic         s_axis_tuser,   // start_of_stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // image_width, image_height, pixel_depth, row_byte_count, background_index,
  // is_interlaced, entry_index, red, green, blue, data_value, zero pad
  output logic [103:0]      m_axis_tdata,
  output logic [3:0]        m_axis_tuser    // event_res
);

  logic        push;
  logic        space;
  gsd_item_t   front_item;
  logic        q_valid;
  logic        pop;
  gsd_item_t   q_item;
  gsd_item_t   out_item;
  logic [15:0] out_row;

  gsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .start_i      (s_axis_tuser),
    .space_i      (space),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .item_o       (front_item)
  );

  gsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  gsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .out_row_o   (out_row)
  );

  assign m_axis_tuser = out_item.event_res;
  assign m_axis_tdata = {3'b000,
                         out_item.data_value,
                         out_item.blue,
                         out_item.green,
                         out_item.red,
                         out_item.entry_index,
                         out_item.is_interlaced,
                         out_item.background_index,
                         out_row,
                         out_item.pixel_depth,
                         out_item.image_height,
                         out_item.image_width};

endmodule

`default_nettype wire

>>> rtl/gsd_front.sv
// gsd_front: byte parser state machine, one byte per transfer
// depends on gsd_pkg

`default_nettype none

module gsd_front import gsd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       start_i,
  input  wire logic       space_i,
  output logic            byte_ready_o,
  output logic            push_o,
  output gsd_item_t       item_o
);

  localparam logic [3:0] M_HEADER   = 4'd0;
  localparam logic [3:0] M_GPAL     = 4'd1;
  localparam logic [3:0] M_BLOCK    = 4'd2;
  localparam logic [3:0] M_LABEL    = 4'd3;
  localparam logic [3:0] M_GCE      = 4'd4;
  localparam logic [3:0] M_SKIP     = 4'd5;
  localparam logic [3:0] M_DESC     = 4'd6;
  localparam logic [3:0] M_LPAL     = 4'd7;
  localparam logic [3:0] M_CODESIZE = 4'd8;
  localparam logic [3:0] M_DATA     = 4'd9;
  localparam logic [3:0] M_DONE     = 4'd10;
  localparam logic [3:0] M_ERROR    = 4'd11;

  localparam logic [7:0] ImageSep  = 8'h2c;
  localparam logic [7:0] ExtIntro  = 8'h21;
  localparam logic [7:0] GceLabel  = 8'hf9;
  localparam logic [7:0] SigG      = 8'h47;
  localparam logic [7:0] SigI      = 8'h49;
  localparam logic [7:0] SigF      = 8'h46;

  function automatic logic [3:0] round_depth(input logic [3:0] raw);
    logic [3:0] r;
    begin
      if (raw <= 4'd1) r = 4'd1;
      else if (raw <= 4'd4) r = 4'd4;
      else r = 4'd8;
      return r;
    end
  endfunction

  logic [3:0]  mode_q, mode_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [3:0]  depth_q, depth_d;
  logic [8:0]  pal_size_q, pal_size_d;
  logic [8:0]  pal_pos_q, pal_pos_d;
  logic [1:0]  tri_q, tri_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  packed_q, packed_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  bg_q, bg_d;

  logic accept;

  assign byte_ready_o = space_i;
  assign accept       = byte_valid_i & space_i;

  always_comb begin
    logic [3:0] n;
    logic [3:0] raw;
    logic [8:0] pos_next;
    logic       is_pal;
    logic [3:0] pal_next_mode;
    logic [3:0] pal_ev;

    mode_d     = mode_q;
    cnt_d      = cnt_q;
    width_d    = width_q;
    height_d   = height_q;
    depth_d    = depth_q;
    pal_size_d = pal_size_q;
    pal_pos_d  = pal_pos_q;
    tri_d      = tri_q;
    red_d      = red_q;
    green_d    = green_q;
    packed_d   = packed_q;
    low_d      = low_q;
    left_d     = left_q;
    bg_d       = bg_q;
    push_o     = 1'b0;
    item_o     = '0;
    n          = '0;
    raw        = '0;
    pos_next   = '0;
    is_pal     = 1'b0;
    pal_next_mode = M_BLOCK;
    pal_ev     = EV_GPAL;

    if (start_i) begin
      mode_d     = M_HEADER;
      cnt_d      = '0;
      width_d    = '0;
      height_d   = '0;
      depth_d    = 4'd1;
      pal_size_d = '0;
      pal_pos_d  = '0;
      tri_d      = '0;
      red_d      = '0;
      green_d    = '0;
      packed_d   = '0;
      low_d      = '0;
      left_d     = '0;
      bg_d       = '0;
    end

    unique case (mode_d)
      M_HEADER: begin
        n     = cnt_d;
        cnt_d = n + 4'd1;
        if ((n == 4'd0 && byte_i != SigG) || (n == 4'd1 && byte_i != SigI) ||
            (n == 4'd2 && byte_i != SigF)) begin
          mode_d           = M_ERROR;
          push_o           = 1'b1;
          item_o.event_res = EV_ERROR;
          item_o.data_value = byte_i;
        end else if (n == 4'd6 || n == 4'd8) begin
          low_d = byte_i;
        end else if (n == 4'd7) begin
          width_d = {byte_i, low_d};
        end else if (n == 4'd9) begin
          height_d = {byte_i, low_d};
        end else if (n == 4'd10) begin
          packed_d = byte_i;
        end else if (n == 4'd11) begin
          bg_d = byte_i;
        end else if (n == 4'd12) begin
          raw        = {1'b0, packed_d[2:0]} + 4'd1;
          pal_size_d = 9'd1 << raw;
          depth_d    = round_depth(raw);
          pal_pos_d  = '0;
          tri_d      = '0;
          cnt_d      = '0;
          mode_d     = packed_d[7] ? M_GPAL : M_BLOCK;
          push_o     = 1'b1;
          item_o.event_res        = EV_SCREEN;
          item_o.image_width      = width_d;
          item_o.image_height     = height_d;
          item_o.pixel_depth      = depth_d;
          item_o.background_index = bg_d;
        end
      end
      M_GPAL: begin
        is_pal        = 1'b1;
        pal_next_mode = M_BLOCK;
        pal_ev        = EV_GPAL;
      end
      M_BLOCK: begin
        if (byte_i == ImageSep) begin
          mode_d = M_DESC;
          cnt_d  = '0;
        end else if (byte_i == ExtIntro) begin
          mode_d = M_LABEL;
        end else begin
          mode_d            = M_ERROR;
          push_o            = 1'b1;
          item_o.event_res  = EV_ERROR;
          item_o.data_value = byte_i;
        end
      end
      M_LABEL: begin
        cnt_d  = '0;
        left_d = '0;
        mode_d = (byte_i == GceLabel) ? M_GCE : M_SKIP;
      end
      M_GCE: begin
        n     = cnt_d;
        cnt_d = n + 4'd1;
        if (n == 4'd1) begin
          packed_d = byte_i;
        end else if (n == 4'd4 && packed_d[0]) begin
          push_o            = 1'b1;
          item_o.event_res  = EV_TRANSP;
          item_o.data_value = byte_i;
        end else if (n >= 4'd5) begin
          cnt_d  = '0;
          mode_d = M_BLOCK;
        end
      end
      M_SKIP: begin
        if (left_d == 8'd0) begin
          if (byte_i == 8'd0) mode_d = M_BLOCK;
          else left_d = byte_i;
        end else begin
          left_d = left_d - 8'd1;
        end
      end
      M_DESC: begin
        n     = cnt_d;
        cnt_d = n + 4'd1;
        if (n == 4'd4 || n == 4'd6) begin
          low_d = byte_i;
        end else if (n == 4'd5) begin
          width_d = {byte_i, low_d};
        end else if (n == 4'd7) begin
          height_d = {byte_i, low_d};
        end else if (n >= 4'd8) begin
          packed_d = byte_i;
          cnt_d    = '0;
          if (byte_i[7]) begin
            raw        = {1'b0, byte_i[2:0]} + 4'd1;
            pal_size_d = 9'd1 << raw;
            depth_d    = round_depth(raw);
            pal_pos_d  = '0;
            tri_d      = '0;
            mode_d     = M_LPAL;
          end else begin
            mode_d = M_CODESIZE;
          end
          push_o               = 1'b1;
          item_o.event_res     = EV_DESC;
          item_o.image_width   = width_d;
          item_o.image_height  = height_d;
          item_o.pixel_depth   = depth_d;
          item_o.is_interlaced = byte_i[6];
        end
      end
      M_LPAL: begin
        is_pal        = 1'b1;
        pal_next_mode = M_CODESIZE;
        pal_ev        = EV_LPAL;
      end
      M_CODESIZE: begin
        left_d            = '0;
        mode_d            = M_DATA;
        push_o            = 1'b1;
        item_o.event_res  = EV_CODE_SIZE;
        item_o.data_value = byte_i;
      end
      M_DATA: begin
        if (left_d == 8'd0) begin
          if (byte_i == 8'd0) begin
            mode_d           = M_DONE;
            push_o           = 1'b1;
            item_o.event_res = EV_END;
          end else begin
            left_d = byte_i;
          end
        end else begin
          left_d            = left_d - 8'd1;
          push_o            = 1'b1;
          item_o.event_res  = EV_DATA;
          item_o.data_value = byte_i;
        end
      end
      default: begin
      end
    endcase

    if (is_pal) begin
      unique case (tri_d)
        2'd0: begin
          red_d = byte_i;
          tri_d = 2'd1;
        end
        2'd1: begin
          green_d = byte_i;
          tri_d   = 2'd2;
        end
        default: begin
          tri_d  = 2'd0;
          push_o = 1'b1;
          item_o.event_res   = gsd_event_e'(pal_ev);
          item_o.entry_index = pal_pos_d[7:0];
          item_o.red         = red_d;
          item_o.green       = green_d;
          item_o.blue        = byte_i;
          pos_next  = pal_pos_d + 9'd1;
          pal_pos_d = pos_next;
          if (pos_next >= pal_size_d || pos_next == 9'd0) mode_d = pal_next_mode;
        end
      endcase
    end

    push_o = push_o & accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_HEADER;
      cnt_q      <= '0;
      width_q    <= '0;
      height_q   <= '0;
      depth_q    <= 4'd1;
      pal_size_q <= '0;
      pal_pos_q  <= '0;
      tri_q      <= '0;
      red_q      <= '0;
      green_q    <= '0;
      packed_q   <= '0;
      low_q      <= '0;
      left_q     <= '0;
      bg_q       <= '0;
    end else if (accept) begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      pal_size_q <= pal_size_d;
      pal_pos_q  <= pal_pos_d;
      tri_q      <= tri_d;
      red_q      <= red_d;
      green_q    <= green_d;
      packed_q   <= packed_d;
      low_q      <= low_d;
      left_q     <= left_d;
      bg_q       <= bg_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gsd_queue.sv
// gsd_queue: short fifo of classified events between parser and output stage
// depends on gsd_pkg

`default_nettype none

module gsd_queue import gsd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire gsd_item_t item_i,
  output logic           space_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output gsd_item_t      item_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  gsd_item_t         mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign space_o = count_q != CntW'(QDepth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & space_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

`default_nettype wire

>>> rtl/gsd_back.sv
// gsd_back: output stage, derives row bytes and holds the result register
// depends on gsd_pkg

`default_nettype none

module gsd_back import gsd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire gsd_item_t    q_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output gsd_item_t         out_item_o,
  output logic [15:0]       out_row_o
);

  logic        valid_q;
  gsd_item_t   item_q;
  logic [15:0] row_q, row_d;
  logic [19:0] prod;
  logic [19:0] rounded;

  assign pop_o       = q_valid_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
  assign out_row_o   = row_q;

  always_comb begin
    prod    = 20'(q_item_i.image_width) * 20'(q_item_i.pixel_depth);
    rounded = prod + 20'd7;
    if (q_item_i.event_res == EV_SCREEN || q_item_i.event_res == EV_DESC) begin
      row_d = rounded[18:3];
    end else begin
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
      row_q  <= row_d;
    end
  end

endmodule

`default_nettype wire

>>> tb/gsd_tb_pkg.sv
// gsd_tb_pkg: byte codes and flag masks of the gif container format
// shared by the deframer checker and the testbench top; no dependencies

package gsd_tb_pkg;

  localparam logic [7:0] SigG           = 8'h47;
  localparam logic [7:0] SigI           = 8'h49;
  localparam logic [7:0] SigF           = 8'h46;
  localparam logic [7:0] ExtIntro       = 8'h21;
  localparam logic [7:0] ImageSep       = 8'h2c;
  localparam logic [7:0] Trailer        = 8'h3b;
  localparam logic [7:0] GceLabel       = 8'hf9;
  localparam logic [7:0] PalettePresent = 8'h80;
  localparam logic [7:0] InterlaceFlag  = 8'h40;
  localparam logic [7:0] TranspFlag     = 8'h01;

endpackage

>>> tb/gsd_checker.sv
// gsd_checker: watches both stream channels of the gif stream deframer, predicts
// the event, if any, for every accepted byte and compares each output transfer in order
// depends on gsd_pkg and gsd_tb_pkg

module gsd_checker import gsd_pkg::*; import gsd_tb_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  input  wire logic         s_tready_i,
  input  wire logic [7:0]   s_tdata_i,   // byte_in
  input  wire logic         s_tuser_i,   // start_of_stream
  input  wire logic         m_tvalid_i,
  input  wire logic         m_tready_i,
  // image_width, image_height, pixel_depth, row_byte_count, background_index,
  // is_interlaced, entry_index, red, green, blue, data_value, zero pad
  input  wire logic [103:0] m_tdata_i,
  input  wire logic [3:0]   m_tuser_i,   // event_res
  output int                fail_count_o,
  output int                pending_o
);

  typedef enum logic [3:0] {
    PM_HEADER, PM_GPAL, PM_BLOCK, PM_LABEL, PM_GCE, PM_SKIP,
    PM_DESC, PM_LPAL, PM_CODESIZE, PM_DATA, PM_DONE, PM_ERROR
  } parse_mode_e;

  typedef struct packed {
    gsd_event_e  ev;
    logic [15:0] width;
    logic [15:0] height;
    logic [3:0]  depth;
    logic [15:0] row_bytes;
    logic [7:0]  background;
    logic        interlaced;
    logic [7:0]  entry;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  data_value;
  } deframe_result_t;

  deframe_result_t event_q[$];
  int fails;

  parse_mode_e mode_q;
  logic [3:0]  field_cnt;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [3:0]  depth_q;
  logic [8:0]  pal_size;
  logic [8:0]  pal_pos;
  logic [1:0]  triple;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  packed_q;
  logic [7:0]  low_q;
  logic [7:0]  left_q;
  logic [7:0]  bg_q;
  logic        transp_seen;

  function automatic void clear_parser();
    mode_q      = PM_HEADER;
    field_cnt   = '0;
    width_q     = '0;
    height_q    = '0;
    depth_q     = 4'd1;
    pal_size    = '0;
    pal_pos     = '0;
    triple      = '0;
    red_q       = '0;
    green_q     = '0;
    packed_q    = '0;
    low_q       = '0;
    left_q      = '0;
    bg_q        = '0;
    transp_seen = 1'b0;
  endfunction

  function automatic logic [3:0] round_depth(logic [3:0] raw);
    if (raw <= 4'd1) return 4'd1;
    if (raw <= 4'd4) return 4'd4;
    return 4'd8;
  endfunction

  function automatic void load_palette(logic [7:0] packed_byte);
    logic [3:0] raw;
    raw      = {1'b0, packed_byte[2:0]} + 4'd1;
    pal_size = 9'd1 << raw;
    depth_q  = round_depth(raw);
    pal_pos  = '0;
    triple   = '0;
  endfunction

  function automatic deframe_result_t plain_event(gsd_event_e ev, logic [7:0] d);
    deframe_result_t r;
    r            = '0;
    r.ev         = ev;
    r.data_value = d;
    return r;
  endfunction

  function automatic deframe_result_t dims_event(gsd_event_e ev);
    deframe_result_t r;
    logic [31:0]     rb;
    rb          = ({16'd0, width_q} * {28'd0, depth_q} + 32'd7) >> 3;
    r           = plain_event(ev, 8'd0);
    r.width     = width_q;
    r.height    = height_q;
    r.depth     = depth_q;
    r.row_bytes = rb[15:0];
    return r;
  endfunction

  function automatic bit palette_byte(logic [7:0] b, gsd_event_e ev, parse_mode_e after_mode,
                                      output deframe_result_t r);
    r = '0;
    case (triple)
      2'd0: begin
        red_q  = b;
        triple = 2'd1;
        return 1'b0;
      end
      2'd1: begin
        green_q = b;
        triple  = 2'd2;
        return 1'b0;
      end
      default: begin
        triple  = 2'd0;
        r       = plain_event(ev, 8'd0);
        r.entry = pal_pos[7:0];
        r.red   = red_q;
        r.green = green_q;
        r.blue  = b;
        pal_pos = pal_pos + 9'd1;
        if (pal_pos >= pal_size || pal_pos == 9'd0) mode_q = after_mode;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit parse_byte(logic [7:0] b, logic sos, output deframe_result_t r);
    logic [3:0] n;
    r = '0;
    if (sos) clear_parser();
    case (mode_q)
      PM_HEADER: begin
        n         = field_cnt;
        field_cnt = n + 4'd1;
        if ((n == 4'd0 && b != SigG) || (n == 4'd1 && b != SigI) ||
            (n == 4'd2 && b != SigF)) begin
          mode_q = PM_ERROR;
          r      = plain_event(EV_ERROR, b);
          return 1'b1;
        end
        case (n)
          4'd6, 4'd8: low_q = b;
          4'd7: width_q = {b, low_q};
          4'd9: height_q = {b, low_q};
          4'd10: packed_q = b;
          4'd11: bg_q = b;
          4'd12: begin
            load_palette(packed_q);
            field_cnt    = '0;
            mode_q       = ((packed_q & PalettePresent) != 8'd0) ? PM_GPAL : PM_BLOCK;
            r            = dims_event(EV_SCREEN);
            r.background = bg_q;
            return 1'b1;
          end
          default: ;
        endcase
        return 1'b0;
      end
      PM_GPAL: return palette_byte(b, EV_GPAL, PM_BLOCK, r);
      PM_BLOCK: begin
        if (b == ImageSep) begin
          mode_q    = PM_DESC;
          field_cnt = '0;
          return 1'b0;
        end
        if (b == ExtIntro) begin
          mode_q = PM_LABEL;
          return 1'b0;
        end
        mode_q = PM_ERROR;
        r      = plain_event(EV_ERROR, b);
        return 1'b1;
      end
      PM_LABEL: begin
        field_cnt = '0;
        left_q    = '0;
        mode_q    = (b == GceLabel) ? PM_GCE : PM_SKIP;
        return 1'b0;
      end
      PM_GCE: begin
        n         = field_cnt;
        field_cnt = n + 4'd1;
        if (n == 4'd1) packed_q = b;
        else if (n == 4'd4 && (packed_q & TranspFlag) != 8'd0) begin
          transp_seen = 1'b1;
          r           = plain_event(EV_TRANSP, b);
          return 1'b1;
        end else if (n >= 4'd5) begin
          field_cnt = '0;
          mode_q    = PM_BLOCK;
        end
        return 1'b0;
      end
      PM_SKIP: begin
        if (left_q == 8'd0) begin
          if (b == 8'd0) mode_q = PM_BLOCK;
          else left_q = b;
        end else begin
          left_q = left_q - 8'd1;
        end
        return 1'b0;
      end
      PM_DESC: begin
        n         = field_cnt;
        field_cnt = n + 4'd1;
        if (n == 4'd4 || n == 4'd6) low_q = b;
        else if (n == 4'd5) width_q = {b, low_q};
        else if (n == 4'd7) height_q = {b, low_q};
        else if (n >= 4'd8) begin
          packed_q  = b;
          field_cnt = '0;
          if ((b & PalettePresent) != 8'd0) begin
            load_palette(b);
            mode_q = PM_LPAL;
          end else begin
            mode_q = PM_CODESIZE;
          end
          r            = dims_event(EV_DESC);
          r.interlaced = (b & InterlaceFlag) != 8'd0;
          return 1'b1;
        end
        return 1'b0;
      end
      PM_LPAL: return palette_byte(b, EV_LPAL, PM_CODESIZE, r);
      PM_CODESIZE: begin
        left_q = '0;
        mode_q = PM_DATA;
        r      = plain_event(EV_CODE_SIZE, b);
        return 1'b1;
      end
      PM_DATA: begin
        if (left_q == 8'd0) begin
          if (b == 8'd0) begin
            mode_q = PM_DONE;
            r      = plain_event(EV_END, 8'd0);
            return 1'b1;
          end
          left_q = b;
          return 1'b0;
        end
        left_q = left_q - 8'd1;
        r      = plain_event(EV_DATA, b);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string show(deframe_result_t x);
    return $sformatf("ev=%0d w=%0d h=%0d d=%0d rb=%0d bg=%0d il=%0b ix=%0d rgb=%0d/%0d/%0d dv=%0d",
                     x.ev, x.width, x.height, x.depth, x.row_bytes, x.background,
                     x.interlaced, x.entry, x.red, x.green, x.blue, x.data_value);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deframe_result_t seen;
    deframe_result_t want;
    bit              has;
    if (!rst_ni) begin
      clear_parser();
      event_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.ev         = gsd_event_e'(m_tuser_i);
        seen.width      = m_tdata_i[15:0];
        seen.height     = m_tdata_i[31:16];
        seen.depth      = m_tdata_i[35:32];
        seen.row_bytes  = m_tdata_i[51:36];
        seen.background = m_tdata_i[59:52];
        seen.interlaced = m_tdata_i[60];
        seen.entry      = m_tdata_i[68:61];
        seen.red        = m_tdata_i[76:69];
        seen.green      = m_tdata_i[84:77];
        seen.blue       = m_tdata_i[92:85];
        seen.data_value = m_tdata_i[100:93];
        if (event_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: %s", show(seen));
        end else begin
          want = event_q.pop_front();
          if (seen.ev !== want.ev || seen.width !== want.width ||
              seen.height !== want.height || seen.depth !== want.depth ||
              seen.row_bytes !== want.row_bytes || seen.background !== want.background ||
              seen.interlaced !== want.interlaced || seen.entry !== want.entry ||
              seen.red !== want.red || seen.green !== want.green ||
              seen.blue !== want.blue || seen.data_value !== want.data_value) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %s, got %s", show(want), show(seen));
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        has = parse_byte(s_tdata_i, s_tuser_i, want);
        if (has) event_q.push_back(want);
      end
      fail_count_o <= fails;
      pending_o    <= event_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// tb: testbench top for the gif stream deframer; feeds directed and random gif streams,
// stalls both sides at random and judges by the checker's failure and pending counts
// depends on gsd_pkg, gsd_tb_pkg, gsd_checker and gif_stream_deframer

module tb;
  import gsd_pkg::*;
  import gsd_tb_pkg::*;

  localparam int ItemTarget = 1900;
  localparam int StallLimit = 2000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // byte_in
  logic         s_axis_tuser;   // start_of_stream
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // image_width, image_height, pixel_depth, row_byte_count, background_index,
  // is_interlaced, entry_index, red, green, blue, data_value, zero pad
  logic [103:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;   // event_res

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int bytes_sent = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  logic [7:0] gif_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gif_stream_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  gsd_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb failed");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = rx_idle ? int'($urandom_range(0, 7)) : 0;
      repeat (gap) begin
        m_axis_tready <= 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h0001;
      3: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 80));
    endcase
  endfunction

  // mostly small palettes, now and then any size up to 256 entries
  function automatic logic [2:0] pick_size();
    return ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
  endfunction

  task automatic put_random(int count);
    repeat (count) gif_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_word(logic [15:0] w);
    gif_q.push_back(w[7:0]);
    gif_q.push_back(w[15:8]);
  endtask

  task automatic put_palette(logic [2:0] sz);
    repeat (3 * (2 << sz)) gif_q.push_back(pick_byte());
  endtask

  task automatic build_gif();
    logic [7:0] flags;
    logic [7:0] label;
    int         len;
    gif_q.delete();
    gif_q.push_back(SigG);
    gif_q.push_back(SigI);
    gif_q.push_back(SigF);
    put_random(3);
    put_word(pick_word());
    put_word(pick_word());
    flags      = 8'($urandom_range(0, 255));
    flags[2:0] = pick_size();
    gif_q.push_back(flags);
    gif_q.push_back(pick_byte());
    put_random(1);
    if ((flags & PalettePresent) != 8'd0) put_palette(flags[2:0]);
    repeat ($urandom_range(0, 3)) begin
      gif_q.push_back(ExtIntro);
      if ($urandom_range(0, 1) != 0) begin
        gif_q.push_back(GceLabel);
        gif_q.push_back(($urandom_range(0, 7) != 0) ? 8'd4 : pick_byte());
        put_random(3);
        gif_q.push_back(pick_byte());
        gif_q.push_back(($urandom_range(0, 7) != 0) ? 8'd0 : pick_byte());
      end else begin
        do label = 8'($urandom_range(0, 255)); while (label == GceLabel);
        gif_q.push_back(label);
        repeat ($urandom_range(0, 2)) begin
          len = $urandom_range(1, 6);
          gif_q.push_back(8'(len));
          put_random(len);
        end
        gif_q.push_back(8'd0);
      end
    end
    gif_q.push_back(ImageSep);
    put_random(4);
    put_word(pick_word());
    put_word(pick_word());
    flags      = 8'($urandom_range(0, 255));
    flags[2:0] = pick_size();
    gif_q.push_back(flags);
    if ((flags & PalettePresent) != 8'd0) put_palette(flags[2:0]);
    gif_q.push_back(pick_byte());
    repeat ($urandom_range(0, 3)) begin
      len = ($urandom_range(0, 19) == 0) ? 255 : int'($urandom_range(1, 8));
      gif_q.push_back(8'(len));
      put_random(len);
    end
    gif_q.push_back(8'd0);
  endtask

  task automatic send_byte(logic [7:0] value, logic sos);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 7)) : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= sos;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_stream();
    foreach (gif_q[i]) send_byte(gif_q[i], i == 0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    int kind;
    int cut;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bad signature at each position, bytes after an error ignored
    gif_q = {8'hff, SigG};
    send_stream();
    gif_q = {SigG, 8'h00};
    send_stream();
    gif_q = {SigG, SigI, 8'h00};
    send_stream();
    // widest screen, deepest palette field, trailer where a block is expected
    gif_q = {SigG, SigI, SigF, 8'h38, 8'h39, 8'h61, 8'hff, 8'hff, 8'hff, 8'hff,
             8'h07, 8'hff, 8'h00, Trailer, ImageSep};
    send_stream();
    drain_results();

    while (bytes_sent < ItemTarget) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      build_gif();
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
        // corrupt one byte
        gif_q[$urandom_range(0, gif_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 8) begin
        // cut the stream short, the next start flag lands mid-parse
        cut = $urandom_range(1, gif_q.size() - 1);
        while (gif_q.size() > cut) void'(gif_q.pop_back());
      end else if (kind == 9) begin
        gif_q.delete();
        put_random($urandom_range(1, 12));
        if ($urandom_range(0, 1) != 0) gif_q[0] = SigG;
      end
      send_stream();
      if (kind < 7 && $urandom_range(0, 3) == 0) begin
        send_byte(Trailer, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
